### rtl/lcc_pkg.sv
package lcc_pkg;

  // Default configuration of the canonicalizer.
  localparam int MaxClauseLenDef = 64;
  localparam int VariableBitsDef = 24;

  // Fixed field widths.
  localparam int SizeW   = 20;
  localparam int StatusW = 3;
  localparam int CountW  = 32;

  // Request kinds.
  localparam logic REQ_ANNOUNCE = 1'b0;
  localparam logic REQ_LITERAL  = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_NO_CLAUSE = 3'd1;
  localparam logic [StatusW-1:0] ST_LENGTH    = 3'd2;
  localparam logic [StatusW-1:0] ST_DUPLICATE = 3'd3;
  localparam logic [StatusW-1:0] ST_TAUTOLOGY = 3'd4;

  // Outcome of one pass through the shared literal comparator.
  typedef struct packed {
    logic ahead;     // a sorts ahead of b
    logic same;      // a equals b
    logic opposite;  // a equals -b
  } cmp_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
    sat_inc = (c == '1) ? c : c + CountW'(1);
  endfunction

endpackage

### rtl/learned_clause_canonicalizer_top.sv
// Channel  | Direction | Handshake                        | Payload
// request  | in        | start high while busy low        | req_type_i, clause_size_i, literal_i
// result   | out       | result_valid_o high, one cycle   | accepted_o, status_o,
//          |           |                                  | sorted_literal_o, last_o, counters
//
// Announce and literal requests leave busy low, and so does a closing
// zero literal that ends in a length mismatch or an empty clause. Otherwise a
// closing zero literal raises busy for an insertion sort, an adjacent-pair
// scan and, when the clause is valid, the emission pass; a clause dropped as
// a duplicate or a tautology skips the emission. The one read port of the
// literal memory and the single comparator serve every pass.
// Reset clears the sequencer, the clause state and the counters at once.
// The receiver cannot stall: each result is shown for exactly one cycle.
module learned_clause_canonicalizer_top
  import lcc_pkg::*;
#(
  parameter int MaxClauseLen = MaxClauseLenDef,
  parameter int VariableBits = VariableBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type_i,
  input  logic [SizeW-1:0]            clause_size_i,
  input  logic signed [VariableBits:0] literal_i,
  output logic                        result_valid_o,
  output logic                        accepted_o,
  output logic [StatusW-1:0]          status_o,
  output logic signed [VariableBits:0] sorted_literal_o,
  output logic                        last_o,
  output logic [CountW-1:0]           offered_count_o,
  output logic [CountW-1:0]           rejected_count_o,
  output logic [CountW-1:0]           stored_count_o
);

  localparam int LitW  = VariableBits + 1;
  localparam int AddrW = (MaxClauseLen > 1) ? $clog2(MaxClauseLen) : 1;
  localparam int IdxW  = $clog2(MaxClauseLen + 1);

  // Sequencer states. Literals are gathered in idle; closing a clause runs
  // an insertion sort in the memory, then an adjacent-pair scan for
  // duplicates and tautologies, then, for a clause that is kept, the emission pass.
  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_SORT_FETCH = 4'd1;
  localparam logic [3:0] S_SORT_LOAD  = 4'd2;
  localparam logic [3:0] S_SORT_CMP   = 4'd3;
  localparam logic [3:0] S_SORT_PLACE = 4'd4;
  localparam logic [3:0] S_SCAN_RD    = 4'd5;
  localparam logic [3:0] S_SCAN_CHK   = 4'd6;
  localparam logic [3:0] S_JUDGE      = 4'd7;
  localparam logic [3:0] S_EMIT_RD    = 4'd8;
  localparam logic [3:0] S_EMIT_OUT   = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [IdxW-1:0]   fill_q, fill_d;
  logic [IdxW-1:0]   expect_q, expect_d;
  logic              ovf_q, ovf_d;
  logic              open_q, open_d;
  logic [CountW-1:0] offered_q, offered_d;
  logic [CountW-1:0] rejected_q, rejected_d;
  logic [CountW-1:0] stored_q, stored_d;
  logic              res_valid_q, res_valid_d;

  logic [IdxW-1:0]   i_q, i_d;
  logic [IdxW-1:0]   j_q, j_d;
  logic [IdxW-1:0]   k_q, k_d;
  logic [LitW-1:0]   v_q, v_d;
  logic [LitW-1:0]   prev_q, prev_d;
  logic              dup_q, dup_d;
  logic              taut_q, taut_d;
  logic              res_acc_q, res_acc_d;
  logic [StatusW-1:0] res_status_q, res_status_d;
  logic [LitW-1:0]   res_lit_q, res_lit_d;
  logic              res_last_q, res_last_d;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [LitW-1:0]   ram_wdata;
  logic [AddrW-1:0]  ram_raddr;
  logic [LitW-1:0]   ram_rdata;

  logic              size_ok;
  logic [IdxW-1:0]   i_m1;
  logic [IdxW-1:0]   j_m2;
  logic [IdxW-1:0]   k_p1;
  logic              sorting;
  logic signed [VariableBits:0] cmp_a;
  logic signed [VariableBits:0] cmp_b;
  cmp_t              cmp;

  lcc_ram #(
    .Width (LitW),
    .Depth (MaxClauseLen)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The one comparator serves both the sort (held value against memory) and
  // the scan (memory against the previous sorted literal).
  assign sorting = (state_q == S_SORT_CMP);
  assign cmp_a   = sorting ? $signed(v_q) : $signed(ram_rdata);
  assign cmp_b   = sorting ? $signed(ram_rdata) : $signed(prev_q);

  lcc_order #(
    .VariableBits (VariableBits)
  ) u_order (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp)
  );

  assign size_ok = (clause_size_i <= SizeW'(MaxClauseLen));
  assign i_m1    = i_q - IdxW'(1);
  assign j_m2    = j_q - IdxW'(2);
  assign k_p1    = k_q + IdxW'(1);
  assign busy    = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    expect_d     = expect_q;
    ovf_d        = ovf_q;
    open_d       = open_q;
    offered_d    = offered_q;
    rejected_d   = rejected_q;
    stored_d     = stored_q;
    res_valid_d  = 1'b0;
    i_d          = i_q;
    j_d          = j_q;
    k_d          = k_q;
    v_d          = v_q;
    prev_d       = prev_q;
    dup_d        = dup_q;
    taut_d       = taut_q;
    res_acc_d    = res_acc_q;
    res_status_d = res_status_q;
    res_lit_d    = res_lit_q;
    res_last_d   = res_last_q;
    ram_we       = 1'b0;
    ram_waddr    = fill_q[AddrW-1:0];
    ram_wdata    = literal_i;
    ram_raddr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (req_type_i == REQ_ANNOUNCE) begin
            // A new announce discards any clause that is still open.
            offered_d = sat_inc(offered_q);
            if (!size_ok) begin
              rejected_d = sat_inc(rejected_q);
            end
            open_d       = size_ok;
            fill_d       = '0;
            ovf_d        = 1'b0;
            expect_d     = size_ok ? clause_size_i[IdxW-1:0] : '0;
            res_valid_d  = 1'b1;
            res_acc_d    = size_ok;
            res_status_d = ST_OK;
            res_lit_d    = '0;
            res_last_d   = 1'b1;
          end else if (!open_q) begin
            res_valid_d  = 1'b1;
            res_acc_d    = 1'b0;
            res_status_d = ST_NO_CLAUSE;
            res_lit_d    = '0;
            res_last_d   = 1'b1;
          end else if (literal_i != '0) begin
            if (fill_q != IdxW'(MaxClauseLen)) begin
              ram_we = 1'b1;
              fill_d = fill_q + IdxW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            open_d       = 1'b0;
            res_acc_d    = 1'b0;
            res_lit_d    = '0;
            res_last_d   = 1'b1;
            res_status_d = ST_OK;
            if (ovf_q || (fill_q != expect_q)) begin
              res_valid_d  = 1'b1;
              res_status_d = ST_LENGTH;
            end else if (fill_q == '0) begin
              // An empty clause is valid and reported as a single zero.
              stored_d    = sat_inc(stored_q);
              res_valid_d = 1'b1;
            end else begin
              i_d     = IdxW'(1);
              state_d = S_SORT_FETCH;
            end
          end
        end
      end

      S_SORT_FETCH: begin
        if (i_q == fill_q) begin
          k_d     = '0;
          dup_d   = 1'b0;
          taut_d  = 1'b0;
          state_d = S_SCAN_RD;
        end else begin
          ram_raddr = i_q[AddrW-1:0];
          state_d   = S_SORT_LOAD;
        end
      end

      S_SORT_LOAD: begin
        v_d       = ram_rdata;
        j_d       = i_q;
        ram_raddr = i_m1[AddrW-1:0];
        state_d   = S_SORT_CMP;
      end

      S_SORT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[AddrW-1:0];
        if (cmp.ahead) begin
          // Shift the larger literal up one place and look one further down.
          ram_wdata = ram_rdata;
          j_d       = j_q - IdxW'(1);
          if (j_q == IdxW'(1)) begin
            state_d = S_SORT_PLACE;
          end else begin
            ram_raddr = j_m2[AddrW-1:0];
          end
        end else begin
          ram_wdata = v_q;
          i_d       = i_q + IdxW'(1);
          state_d   = S_SORT_FETCH;
        end
      end

      S_SORT_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[AddrW-1:0];
        ram_wdata = v_q;
        i_d       = i_q + IdxW'(1);
        state_d   = S_SORT_FETCH;
      end

      S_SCAN_RD: begin
        ram_raddr = k_q[AddrW-1:0];
        state_d   = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        if (k_q != '0) begin
          dup_d  = dup_q | cmp.same;
          taut_d = taut_q | cmp.opposite;
        end
        prev_d  = ram_rdata;
        k_d     = k_p1;
        state_d = (k_p1 == fill_q) ? S_JUDGE : S_SCAN_RD;
      end

      S_JUDGE: begin
        res_acc_d  = 1'b0;
        res_lit_d  = '0;
        res_last_d = 1'b1;
        // Duplicates take priority over tautologies.
        if (dup_q) begin
          res_valid_d  = 1'b1;
          res_status_d = ST_DUPLICATE;
          state_d      = S_IDLE;
        end else if (taut_q) begin
          res_valid_d  = 1'b1;
          res_status_d = ST_TAUTOLOGY;
          state_d      = S_IDLE;
        end else begin
          stored_d = sat_inc(stored_q);
          k_d      = '0;
          state_d  = S_EMIT_RD;
        end
      end

      S_EMIT_RD: begin
        ram_raddr = k_q[AddrW-1:0];
        state_d   = S_EMIT_OUT;
      end

      S_EMIT_OUT: begin
        res_valid_d  = 1'b1;
        res_acc_d    = 1'b0;
        res_status_d = ST_OK;
        res_lit_d    = ram_rdata;
        res_last_d   = (k_p1 == fill_q);
        k_d          = k_p1;
        state_d      = (k_p1 == fill_q) ? S_IDLE : S_EMIT_RD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      expect_q    <= '0;
      ovf_q       <= 1'b0;
      open_q      <= 1'b0;
      offered_q   <= '0;
      rejected_q  <= '0;
      stored_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      expect_q    <= expect_d;
      ovf_q       <= ovf_d;
      open_q      <= open_d;
      offered_q   <= offered_d;
      rejected_q  <= rejected_d;
      stored_q    <= stored_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q          <= i_d;
    j_q          <= j_d;
    k_q          <= k_d;
    v_q          <= v_d;
    prev_q       <= prev_d;
    dup_q        <= dup_d;
    taut_q       <= taut_d;
    res_acc_q    <= res_acc_d;
    res_status_q <= res_status_d;
    res_lit_q    <= res_lit_d;
    res_last_q   <= res_last_d;
  end

  // The counters already hold their post-request values when a result shows.
  assign result_valid_o   = res_valid_q;
  assign accepted_o       = res_acc_q;
  assign status_o         = res_status_q;
  assign sorted_literal_o = $signed(res_lit_q);
  assign last_o           = res_last_q;
  assign offered_count_o  = offered_q;
  assign rejected_count_o = rejected_q;
  assign stored_count_o   = stored_q;

endmodule

### rtl/lcc_ram.sv
module lcc_ram #(
  parameter int Width = 25,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lcc_order.sv
module lcc_order
  import lcc_pkg::*;
#(
  parameter int VariableBits = VariableBitsDef
) (
  input  logic signed [VariableBits:0] a_i,
  input  logic signed [VariableBits:0] b_i,
  output cmp_t                         res_o
);

  localparam int LitW = VariableBits + 1;

  logic        [LitW-1:0] mag_a;
  logic        [LitW-1:0] mag_b;
  logic signed [LitW:0]   a_ext;
  logic signed [LitW:0]   b_neg;

  // The most negative literal wraps to 2^VariableBits, which is its true
  // magnitude when read as unsigned.
  assign mag_a = a_i[VariableBits] ? $unsigned(-a_i) : $unsigned(a_i);
  assign mag_b = b_i[VariableBits] ? $unsigned(-b_i) : $unsigned(b_i);

  // Negation is done one bit wider so the most negative literal has no match.
  assign a_ext = {a_i[VariableBits], a_i};
  assign b_neg = -{b_i[VariableBits], b_i};

  assign res_o.ahead    = (mag_a != mag_b) ? (mag_a < mag_b) : (a_i < b_i);
  assign res_o.same     = (a_i == b_i);
  assign res_o.opposite = (a_ext == b_neg);

endmodule
